// ===== rtl/binned_count_sum_average_core_macros.svh =====
// Assertion macros shared by the binned count, sum and average block.
`ifndef BINNED_COUNT_SUM_AVERAGE_CORE_MACROS_SVH
`define BINNED_COUNT_SUM_AVERAGE_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BCSA_ASSERT_NOW(name, clk, rst, cond, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BCSA_ASSERT_NEXT(name, clk, rst, cond, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== rtl/bcsa_pkg.sv =====
// Package with the constants, types and encodings of the binned count, sum and average block.
package bcsa_pkg;

   localparam int BIN_COUNT  = 2048;
   localparam int COUNT_BITS = 20;
   localparam int SUM_BITS   = 28;

   localparam int IDX_BITS = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

   localparam int KIND_BITS      = 1;
   localparam int BIN_INDEX_BITS = 11;
   localparam int RATING_BITS    = 8;
   localparam int OUT_COUNT_BITS = 20;
   localparam int OUT_SUM_BITS   = 28;
   localparam int AVG_BITS       = 16;
   localparam int AVG_FRAC_BITS  = 8;
   localparam int STATUS_BITS    = 2;

   localparam int STEP_BITS = $clog2(AVG_BITS);
   localparam int CMP_BITS  =
      ((SUM_BITS > COUNT_BITS + AVG_FRAC_BITS) ? SUM_BITS : COUNT_BITS + AVG_FRAC_BITS) + 1;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_ADD  = 1'b0,
      KIND_READ = 1'b1
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_SAT   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_UPDATE,
      S_START,
      S_DIVIDE,
      S_RESPOND
   } state_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic [SUM_BITS-1:0]   sum;
   } row_type;

   typedef struct packed {
      logic                rd_en;
      logic                wr_en;
      logic [IDX_BITS-1:0] addr;
      row_type             wdata;
   } store_cmd_type;

   typedef struct packed {
      logic                  start;
      logic [SUM_BITS-1:0]   sum;
      logic [COUNT_BITS-1:0] count;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic                busy;
      logic [AVG_BITS-1:0] quotient;
   } div_res_type;

endpackage

// ===== rtl/bcsa_if.sv =====
// Valid/ready channel interfaces for request and response items.
interface bcsa_req_if;
   import bcsa_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [KIND_BITS-1:0]      kind;
   logic [BIN_INDEX_BITS-1:0] bin_index;
   logic [RATING_BITS-1:0]    rating;

   modport source (output valid, kind, bin_index, rating, input ready);
   modport sink (input valid, kind, bin_index, rating, output ready);
endinterface

interface bcsa_rsp_if;
   import bcsa_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [OUT_COUNT_BITS-1:0] bin_count;
   logic [OUT_SUM_BITS-1:0]   bin_sum;
   logic [AVG_BITS-1:0]       average_q8;
   logic [STATUS_BITS-1:0]    status;

   modport source (output valid, bin_count, bin_sum, average_q8, status, input ready);
   modport sink (input valid, bin_count, bin_sum, average_q8, status, output ready);
endinterface

// ===== rtl/bcsa_store.sv =====
// Bin store: one count and sum row per bin, cleared by a sweep after reset.
module bcsa_store (
   input  logic                    clock,
   input  logic                    reset,
   input  bcsa_pkg::store_cmd_type cmd,
   output bcsa_pkg::row_type       rdata,
   output logic                    clearing
);
   import bcsa_pkg::*;

   row_type             mem [BIN_COUNT];
   row_type             rdata_ff;
   logic                clear_ff, clear_in;
   logic [IDX_BITS-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == IDX_BITS'(BIN_COUNT - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (cmd.wr_en) begin
         mem[cmd.addr] <= cmd.wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[cmd.addr];
      end
   end

   assign rdata    = rdata_ff;
   assign clearing = clear_ff;
endmodule

// ===== rtl/bcsa_divider.sv =====
// Restoring divider producing the saturated Q8.8 quotient of sum by count, one bit a cycle.
module bcsa_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  bcsa_pkg::div_req_type req,
   output bcsa_pkg::div_res_type res
);
   import bcsa_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic [COUNT_BITS-1:0]    rem_ff, rem_in;
   logic [COUNT_BITS-1:0]    divisor_ff, divisor_in;
   logic [AVG_BITS-1:0]      bits_ff, bits_in;
   logic [AVG_BITS-1:0]      quot_ff, quot_in;
   logic [COUNT_BITS:0]      trial;
   logic                     fits;
   logic                     too_big;

   // The quotient passes the 16-bit range exactly when sum >= count * 256.
   assign too_big = CMP_BITS'(req.sum) >= (CMP_BITS'(req.count) << AVG_FRAC_BITS);
   assign trial   = {rem_ff, bits_ff[AVG_BITS-1]};
   assign fits    = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      bits_in    = bits_ff;
      quot_in    = quot_ff;
      if (req.start) begin
         divisor_in = req.count;
         step_in    = '0;
         if (req.count == '0) begin
            quot_in = '0;
            done_in = 1'b1;
         end else if (too_big) begin
            quot_in = '1;
            done_in = 1'b1;
         end else begin
            // The upper part of sum already lies below the divisor.
            rem_in  = COUNT_BITS'(req.sum >> AVG_FRAC_BITS);
            bits_in = AVG_BITS'(req.sum[AVG_FRAC_BITS-1:0]) << AVG_FRAC_BITS;
            quot_in = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = fits ? COUNT_BITS'(trial - {1'b0, divisor_ff}) : COUNT_BITS'(trial);
         bits_in = bits_ff << 1;
         quot_in = {quot_ff[AVG_BITS-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(AVG_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      bits_ff    <= bits_in;
      quot_ff    <= quot_in;
   end

   assign res.done     = done_ff;
   assign res.busy     = busy_ff;
   assign res.quotient = quot_ff;
endmodule

// ===== rtl/binned_count_sum_average_core.sv =====
// An accepted in-range item's result waits on the 16-step divider; when the count is zero or
// the average saturates the divider skips its steps, and an out-of-range bin goes straight to the response.
// Each in-range item reads its bin row, writes it back on an add, then runs the divider.
// The result is held until taken, and the next item is accepted only after that.
// Synchronous reset; afterwards a sweep clears all 2048 bins with ready low.
`include "binned_count_sum_average_core_macros.svh"

module binned_count_sum_average_core (
   input  logic       clock,
   input  logic       reset,
   bcsa_req_if.sink   req_ch,
   bcsa_rsp_if.source rsp_ch
);
   import bcsa_pkg::*;

   state_type             state_ff, state_in;
   store_cmd_type         store_cmd;
   row_type               row;
   logic                  clearing;
   div_req_type           div_req;
   div_res_type           div_res;

   logic                  kind_ff;
   logic [IDX_BITS-1:0]   addr_ff;
   logic [RATING_BITS-1:0] rating_ff;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   status_type            status_ff, status_in;

   logic                  accept;
   logic                  in_range;
   logic [SUM_BITS:0]     sum_wide;

   bcsa_store u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd      (store_cmd),
      .rdata    (row),
      .clearing (clearing)
   );

   bcsa_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .res   (div_res)
   );

   assign accept   = req_ch.valid && req_ch.ready;
   assign in_range = 32'(req_ch.bin_index) < BIN_COUNT;
   assign sum_wide = {1'b0, row.sum} + (SUM_BITS + 1)'(rating_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = in_range ? S_READ : S_RESPOND;
            end
         end
         S_READ:    state_in = S_UPDATE;
         S_UPDATE:  state_in = S_START;
         S_START:   state_in = S_DIVIDE;
         S_DIVIDE: begin
            if (div_res.done) begin
               state_in = S_RESPOND;
            end
         end
         S_RESPOND: begin
            if (rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   // Row update on an add, with both fields held at their maximum.
   always_comb begin
      count_in  = row.count;
      sum_in    = row.sum;
      status_in = ST_OK;
      if (kind_ff == KIND_ADD) begin
         if (&row.count) begin
            status_in = ST_SAT;
         end else begin
            count_in = row.count + 1'b1;
         end
         if (sum_wide[SUM_BITS]) begin
            sum_in    = '1;
            status_in = ST_SAT;
         end else begin
            sum_in = sum_wide[SUM_BITS-1:0];
         end
      end
   end

   // Outputs.
   always_comb begin
      req_ch.ready      = 1'b0;
      store_cmd.rd_en   = 1'b0;
      store_cmd.wr_en   = 1'b0;
      store_cmd.addr    = addr_ff;
      store_cmd.wdata   = '{count: count_in, sum: sum_in};
      div_req.start     = 1'b0;
      div_req.sum       = sum_ff;
      div_req.count     = count_ff;
      rsp_ch.valid      = 1'b0;
      rsp_ch.bin_count  = OUT_COUNT_BITS'(count_ff);
      rsp_ch.bin_sum    = OUT_SUM_BITS'(sum_ff);
      rsp_ch.status     = status_ff;
      rsp_ch.average_q8 = (status_ff == ST_RANGE) ? '0 : div_res.quotient;
      case (state_ff)
         S_IDLE:    req_ch.ready = !clearing;
         S_READ:    store_cmd.rd_en = 1'b1;
         S_UPDATE:  store_cmd.wr_en = (kind_ff == KIND_ADD);
         S_START:   div_req.start = 1'b1;
         S_DIVIDE:  ;
         S_RESPOND: rsp_ch.valid = 1'b1;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_ch.kind;
         addr_ff   <= IDX_BITS'(req_ch.bin_index);
         rating_ff <= req_ch.rating;
         count_ff  <= '0;
         sum_ff    <= '0;
         status_ff <= in_range ? ST_OK : ST_RANGE;
      end else if (state_ff == S_UPDATE) begin
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         status_ff <= status_in;
      end
   end

   `BCSA_ASSERT_NOW(a_no_accept_while_clearing, clock, reset, clearing, !req_ch.ready,
      "item accepted while the bin store is being cleared")
   `BCSA_ASSERT_NOW(a_range_result_zero, clock, reset,
      rsp_ch.valid && (rsp_ch.status == ST_RANGE),
      (rsp_ch.bin_count == '0) && (rsp_ch.bin_sum == '0) && (rsp_ch.average_q8 == '0),
      "out-of-range item returned nonzero fields")
   `BCSA_ASSERT_NOW(a_div_done_in_divide, clock, reset, div_res.done, state_ff == S_DIVIDE,
      "divider finished outside the divide phase")
   `BCSA_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, state_ff != S_IDLE,
      "accepted item did not start processing")
   `BCSA_ASSERT_NOW(a_write_not_on_read, clock, reset, store_cmd.wr_en,
      (kind_ff == KIND_ADD) && !store_cmd.rd_en,
      "bin store written by a read item")
endmodule
